>>> hw/rtl/bup_pkg.sv
// Shared types, register codes, constants and table functions of the bubble universe plotter.
package bup_pkg;

	typedef struct packed {
		logic        command;
		logic [15:0] time_phase;
	} req_t;

	typedef struct packed {
		logic [13:0] pixel_index;
		logic [15:0] pixel_color;
		logic        pixel_valid;
		logic        curve_done;
		logic        frame_done;
	} rsp_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_SCALE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_LOG2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITERATION_LOG2  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CURVE_STEP      = 3'd5;

	localparam logic [14:0]        SIZE_SCALE_RST = 15'd4096;
	localparam logic signed [16:0] X_OFFSET_RST   = 17'sd8192;
	localparam logic signed [16:0] Y_OFFSET_RST   = 17'sd8192;
	localparam logic [3:0]         CURVE_LOG2_RST = 4'd8;
	localparam logic [3:0]         ITER_LOG2_RST  = 4'd9;
	localparam logic [4:0]         CURVE_STEP_RST = 5'd4;

	localparam logic [3:0] LOG2_MIN       = 4'd1;
	localparam logic [3:0] CURVE_LOG2_MAX = 4'd10;
	localparam logic [3:0] ITER_LOG2_MAX  = 4'd12;

	localparam logic [31:0] HALF_PI_Q30    = 32'd1686629713;
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam int          INC1_DIV       = 235;
	localparam int          INC1_ROUND     = 117;
	localparam int          TAYLOR_TERMS   = 6;

	// Quarter-wave sine entry in Q1.14, from a Taylor series in Q2.30.
	function automatic logic [15:0] sine_value(input int k, input int sib);
		logic [63:0]        theta;
		logic [63:0]        t2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] rounded;
		theta = (64'(k) * 64'(HALF_PI_Q30)) >> (sib - 2);
		t2 = (theta * theta) >> 30;
		term = theta;
		sum = $signed(theta);
		for (int n = 1; n <= TAYLOR_TERMS; n++) begin
			term = ((term * t2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		rounded = (sum + 64'sd32768) >>> 16;
		return rounded[15:0];
	endfunction

	// Angle increment of the first angle between curves.
	function automatic logic [31:0] inc1_value(input int step, input int sib);
		logic [63:0] v;
		v = ((64'(step) << sib) + 64'(INC1_ROUND)) / 64'(INC1_DIV);
		return v[31:0];
	endfunction

	// Angle increment of the second angle between curves.
	function automatic logic [31:0] inc2_value(input int step, input int sib);
		logic [63:0] v;
		v = ((64'(step) * 64'(INV_TWO_PI_Q32)) << sib) + 64'h8000_0000;
		return v[63:32];
	endfunction

endpackage

>>> hw/rtl/bubble_universe_point_plotter.sv
// Top level of the bubble universe point plotter: sequencer, point state and screen mapping.
//
// Each request yields one response: the next point of the current curve, mapped to a pixel
// index with its RGB565 color, or, when no frame is running, an empty response that carries
// only frame_done. A point request goes from acceptance to the response register through
// forming the two angles, four reads of the single sine ROM port (sine and cosine of both
// angles), collecting the last read, scaling, the screen multiply, truncation, and writing
// the response and the curve state. A request that meets a finished frame goes from the
// angle step straight to the write. The write waits while the consumer stalls the previous
// response; the block then returns to idle and takes no new request before it is through
// with the last one. The next request is accepted as soon as the previous response is in
// the output register, even while the consumer stalls it. The sine ROM is constant, so the
// block is ready directly after reset. Configuration is written through cfg_we, cfg_index
// and cfg_data by the user only while no request is in flight; the block does not check it.
module bubble_universe_point_plotter #(
	parameter int SINE_INDEX_BITS = 16,
	parameter int SCREEN_WIDTH    = 80,
	parameter int SCREEN_HEIGHT   = 160
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  bup_pkg::req_t                     req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output bup_pkg::rsp_t                     rsp,
	input  logic                              cfg_we,
	input  logic [bup_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bup_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int B      = SINE_INDEX_BITS;
	localparam int SH     = 46 - B;
	localparam int PSIZE  = (SCREEN_WIDTH < SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int OX     = (SCREEN_WIDTH - PSIZE) / 2;
	localparam int OY     = (SCREEN_HEIGHT - PSIZE) / 2;
	localparam int PW     = 40 + $clog2(SCREEN_WIDTH + SCREEN_HEIGHT);
	localparam int POS_W  = PW - 28;
	localparam int XW     = $clog2(SCREEN_WIDTH);
	localparam int YW     = $clog2(SCREEN_HEIGHT);
	localparam int IDX_W  = XW + YW;
	localparam logic [B-1:0] QUARTER   = B'(1) << (B - 2);
	localparam logic [1:0]   LAST_LOOK = 2'd3;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_ANGLE = 8'b0000_0010,
		ST_LOOK  = 8'b0000_0100,
		ST_DRAIN = 8'b0000_1000,
		ST_SCALE = 8'b0001_0000,
		ST_PROD  = 8'b0010_0000,
		ST_POS   = 8'b0100_0000,
		ST_WRITE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [14:0]        scale_q;
	logic signed [16:0] xoff_q;
	logic signed [16:0] yoff_q;
	logic [3:0]         clog_q;
	logic [3:0]         ilog_q;
	logic [4:0]         step_q;

	logic [9:0]         curve_q;
	logic [11:0]        iter_q;
	logic signed [16:0] x_q;
	logic signed [16:0] y_q;
	logic [B-1:0]       ang1_q;
	logic [B-1:0]       ang2_q;
	logic               fin_q;

	logic [1:0]         look_cnt_q;
	logic               lut_vld_s1;
	logic [1:0]         lut_tag_s1;
	logic               idle_s1;
	logic [B-1:0]       o1_s1;
	logic [B-1:0]       o2_s1;
	logic signed [16:0] nx_s2;
	logic signed [16:0] ny_s2;
	logic signed [33:0] vx_s3;
	logic signed [33:0] vy_s3;
	logic signed [PW-1:0]    xp_s4;
	logic signed [PW-1:0]    yp_s4;
	logic signed [POS_W-1:0] px_s5;
	logic signed [POS_W-1:0] py_s5;
	logic               rsp_valid_q;
	bup_pkg::rsp_t      rsp_q;
	bup_pkg::rsp_t      rsp_d;

	logic [B-1:0] inc1_tab [32];
	logic [B-1:0] inc2_tab [32];

	logic [3:0]   clog_eff;
	logic [3:0]   ilog_eff;
	logic [4:0]   step_eff;
	logic [10:0]  ccount;
	logic [12:0]  icount;
	logic         out_of_range;
	logic         last_iter;
	logic         last_curve;
	logic         accept;
	logic         wr_go;

	logic signed [47:0] aprod1;
	logic signed [47:0] aprod2;
	logic signed [47:0] ash1;
	logic signed [47:0] ash2;

	logic [B-1:0]       lut_angle;
	logic signed [16:0] lut_val;

	logic signed [33:0] vx_d;
	logic signed [33:0] vy_d;
	logic signed [PW-1:0] tx;
	logic signed [PW-1:0] ty;
	logic signed [PW-1:0] fx;
	logic signed [PW-1:0] fy;
	logic               rx;
	logic               ry;
	logic               on_screen;
	logic [IDX_W-1:0]   idx;
	logic [IDX_W+13:0]  idx_ext;
	logic [17:0]        red_full;
	logic [19:0]        green_full;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [8:0]         rg_sum;

	for (genvar g = 0; g < 32; g++) begin : g_inc
		assign inc1_tab[g] = B'(bup_pkg::inc1_value((g == 0) ? 1 : g, B));
		assign inc2_tab[g] = B'(bup_pkg::inc2_value((g == 0) ? 1 : g, B));
	end

	always_comb begin
		if (clog_q < bup_pkg::LOG2_MIN) begin
			clog_eff = bup_pkg::LOG2_MIN;
		end else if (clog_q > bup_pkg::CURVE_LOG2_MAX) begin
			clog_eff = bup_pkg::CURVE_LOG2_MAX;
		end else begin
			clog_eff = clog_q;
		end
		if (ilog_q < bup_pkg::LOG2_MIN) begin
			ilog_eff = bup_pkg::LOG2_MIN;
		end else if (ilog_q > bup_pkg::ITER_LOG2_MAX) begin
			ilog_eff = bup_pkg::ITER_LOG2_MAX;
		end else begin
			ilog_eff = ilog_q;
		end
	end

	assign step_eff     = (step_q == '0) ? 5'd1 : step_q;
	assign ccount       = 11'(1) << clog_eff;
	assign icount       = 13'(1) << ilog_eff;
	assign out_of_range = ({1'b0, curve_q} >= ccount) || ({1'b0, iter_q} >= icount);
	assign last_iter    = (13'(iter_q) + 13'd1) >= icount;
	assign last_curve   = (11'(curve_q) + 11'(step_eff)) >= ccount;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign wr_go     = (state_q == ST_WRITE) && (!rsp_valid_q || !rsp_stall);

	// Angle offsets: point times 2^B/(2pi), floored to whole table units.
	assign aprod1 = x_q * $signed({1'b0, bup_pkg::INV_TWO_PI_Q32});
	assign aprod2 = y_q * $signed({1'b0, bup_pkg::INV_TWO_PI_Q32});
	assign ash1   = aprod1 >>> SH;
	assign ash2   = aprod2 >>> SH;

	// Reads go sin(o1), sin(o2), cos(o1), cos(o2); cosine is the angle a quarter turn on.
	assign lut_angle = (look_cnt_q[0] ? o2_s1 : o1_s1) + (look_cnt_q[1] ? QUARTER : '0);

	bup_sine_lut #(
		.SINE_INDEX_BITS(SINE_INDEX_BITS)
	) u_lut (
		.clk  (clk),
		.rd   (state_q == ST_LOOK),
		.angle(lut_angle),
		.value(lut_val)
	);

	assign vx_d = 34'(nx_s2) * 34'($signed({1'b0, scale_q})) + (34'(xoff_q) <<< 14);
	assign vy_d = 34'(ny_s2) * 34'($signed({1'b0, scale_q})) + (34'(yoff_q) <<< 14);

	// Truncation toward zero: floor, then one up when negative with a fraction left.
	assign tx = xp_s4 + (PW'(OX) <<< 28);
	assign ty = yp_s4 + (PW'(OY) <<< 28);
	assign fx = tx >>> 28;
	assign fy = ty >>> 28;
	assign rx = tx[PW-1] && (tx[27:0] != '0);
	assign ry = ty[PW-1] && (ty[27:0] != '0);

	assign on_screen = (px_s5 >= 0) && (px_s5 < POS_W'(SCREEN_WIDTH)) &&
		(py_s5 >= 0) && (py_s5 < POS_W'(SCREEN_HEIGHT));
	assign idx = IDX_W'(py_s5[YW-1:0]) * IDX_W'(SCREEN_WIDTH) + IDX_W'(px_s5[XW-1:0]);
	assign idx_ext = {14'b0, idx};

	assign red_full   = {curve_q, 8'b0} >> clog_eff;
	assign green_full = {iter_q, 8'b0} >> ilog_eff;
	assign red        = red_full[7:0];
	assign green      = green_full[7:0];
	assign rg_sum     = {1'b0, red} + {1'b0, green};
	assign blue       = 8'd255 - rg_sum[8:1];

	always_comb begin
		rsp_d = '0;
		if (idle_s1) begin
			rsp_d.frame_done = 1'b1;
		end else begin
			rsp_d.pixel_valid = on_screen;
			rsp_d.pixel_index = on_screen ? idx_ext[13:0] : '0;
			rsp_d.pixel_color = {red[7:3], green[7:2], blue[7:3]};
			rsp_d.curve_done  = last_iter;
			rsp_d.frame_done  = last_iter && last_curve;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= bup_pkg::SIZE_SCALE_RST;
			xoff_q  <= bup_pkg::X_OFFSET_RST;
			yoff_q  <= bup_pkg::Y_OFFSET_RST;
			clog_q  <= bup_pkg::CURVE_LOG2_RST;
			ilog_q  <= bup_pkg::ITER_LOG2_RST;
			step_q  <= bup_pkg::CURVE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bup_pkg::REG_SIZE_SCALE:     scale_q <= cfg_data[14:0];
				bup_pkg::REG_X_OFFSET:       xoff_q  <= $signed(cfg_data);
				bup_pkg::REG_Y_OFFSET:       yoff_q  <= $signed(cfg_data);
				bup_pkg::REG_CURVE_LOG2:     clog_q  <= cfg_data[3:0];
				bup_pkg::REG_ITERATION_LOG2: ilog_q  <= cfg_data[3:0];
				bup_pkg::REG_CURVE_STEP:     step_q  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fin_q       <= 1'b1;
			curve_q     <= '0;
			iter_q      <= '0;
			x_q         <= '0;
			y_q         <= '0;
			ang1_q      <= '0;
			ang2_q      <= '0;
			look_cnt_q  <= '0;
			lut_vld_s1  <= 1'b0;
			idle_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			lut_vld_s1 <= (state_q == ST_LOOK);
			if (wr_go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (req.command) begin
							fin_q   <= 1'b0;
							curve_q <= '0;
							iter_q  <= '0;
							x_q     <= '0;
							y_q     <= '0;
							ang1_q  <= req.time_phase[B-1:0];
							ang2_q  <= req.time_phase[B-1:0];
						end
						state_q <= ST_ANGLE;
					end
				end
				ST_ANGLE: begin
					if (fin_q || out_of_range) begin
						fin_q   <= 1'b1;
						idle_s1 <= 1'b1;
						state_q <= ST_WRITE;
					end else begin
						idle_s1    <= 1'b0;
						look_cnt_q <= '0;
						state_q    <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					look_cnt_q <= look_cnt_q + 2'd1;
					if (look_cnt_q == LAST_LOOK) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_PROD;
				ST_PROD:  state_q <= ST_POS;
				ST_POS:   state_q <= ST_WRITE;
				ST_WRITE: begin
					if (wr_go) begin
						if (!idle_s1) begin
							if (last_iter) begin
								iter_q <= '0;
								x_q    <= '0;
								y_q    <= '0;
								ang1_q <= ang1_q + inc1_tab[step_q];
								ang2_q <= ang2_q + inc2_tab[step_q];
								if (last_curve) begin
									fin_q <= 1'b1;
								end else begin
									curve_q <= 10'(11'(curve_q) + 11'(step_eff));
								end
							end else begin
								iter_q <= iter_q + 12'd1;
								x_q    <= nx_s2;
								y_q    <= ny_s2;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		lut_tag_s1 <= look_cnt_q;
		if (state_q == ST_ANGLE) begin
			o1_s1 <= ang1_q + ash1[B-1:0];
			o2_s1 <= ang2_q + ash2[B-1:0];
		end
		if (lut_vld_s1) begin
			if (lut_tag_s1[1]) begin
				ny_s2 <= lut_tag_s1[0] ? ny_s2 + lut_val : lut_val;
			end else begin
				nx_s2 <= lut_tag_s1[0] ? nx_s2 + lut_val : lut_val;
			end
		end
		if (state_q == ST_SCALE) begin
			vx_s3 <= vx_d;
			vy_s3 <= vy_d;
		end
		if (state_q == ST_PROD) begin
			xp_s4 <= PW'(vx_s3) * PW'(PSIZE);
			yp_s4 <= PW'(vy_s3) * PW'(PSIZE);
		end
		if (state_q == ST_POS) begin
			px_s5 <= POS_W'(fx) + $signed(POS_W'(rx));
			py_s5 <= POS_W'(fy) + $signed(POS_W'(ry));
		end
		if (wr_go) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == ST_ANGLE))
		else $error("accepted request did not start the angle step");

	a_all_reads_in: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (lut_vld_s1 && (lut_tag_s1 == LAST_LOOK)))
		else $error("sine reads out of order when collecting the last one");

	a_empty_response: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.frame_done && !rsp.curve_done) |->
		(!rsp.pixel_valid && (rsp.pixel_color == '0) && (rsp.pixel_index == '0)))
		else $error("frame end without curve end carries pixel data");

endmodule

>>> hw/rtl/bup_sine_lut.sv
// Quarter-wave sine ROM with registered read and quadrant folding.
module bup_sine_lut #(
	parameter int SINE_INDEX_BITS = 16
) (
	input  logic                       clk,
	input  logic                       rd,
	input  logic [SINE_INDEX_BITS-1:0] angle,
	output logic signed [16:0]         value
);

	localparam int KW    = SINE_INDEX_BITS - 2;
	localparam int DEPTH = 1 << KW;

	logic [15:0]   rom_mem [DEPTH];
	logic [1:0]    quad;
	logic [KW-1:0] addr;
	logic [15:0]   data_s1;
	logic          neg_s1;

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign rom_mem[g] = bup_pkg::sine_value(g, SINE_INDEX_BITS);
	end

	assign quad = angle[SINE_INDEX_BITS-1:SINE_INDEX_BITS-2];
	assign addr = angle[KW-1:0] ^ {KW{quad[0]}};

	always_ff @(posedge clk) begin
		if (rd) begin
			data_s1 <= rom_mem[addr];
			neg_s1  <= quad[1];
		end
	end

	assign value = neg_s1 ? -$signed({1'b0, data_s1}) : $signed({1'b0, data_s1});

endmodule

>>> tb/bup_plot_checker.sv
// Watches the plotter's request, response and register ports, predicts every response and compares.
module bup_plot_checker #(
	parameter int SINE_BITS = 16,
	parameter int SCREEN_W  = 80,
	parameter int SCREEN_H  = 160
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_stall,
	input  bup_pkg::req_t                  req,
	input  logic                           rsp_valid,
	input  logic                           rsp_stall,
	input  bup_pkg::rsp_t                  rsp,
	input  logic                           cfg_we,
	input  logic [bup_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bup_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             responses,
	output int                             points,
	output int                             on_screen,
	output int                             curves,
	output int                             frames
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUARTER  = 1 << (SINE_BITS - 2);
	localparam int ANG_MASK = (1 << SINE_BITS) - 1;
	localparam int PLOT     = (SCREEN_W < SCREEN_H) ? SCREEN_W : SCREEN_H;
	localparam int ORG_X    = (SCREEN_W - PLOT) / 2;
	localparam int ORG_Y    = (SCREEN_H - PLOT) / 2;

	logic [15:0] sine_tab [QUARTER];

	logic [14:0] scale_q;
	int          x_off;
	int          y_off;
	logic [3:0]  curve_log2;
	logic [3:0]  iter_log2;
	logic [4:0]  step_r;

	int unsigned curve_no;
	int unsigned iter_no;
	int          x_pt;
	int          y_pt;
	int unsigned angle1;
	int unsigned angle2;
	bit          frame_idle;

	bup_pkg::rsp_t expected_points [$];
	int   mism;
	int   n_rsp;
	int   n_pts;
	int   n_on;
	int   n_curves;
	int   n_frames;

	function automatic logic [15:0] taylor_sine(input int k);
		logic [63:0] theta;
		logic [63:0] sq;
		logic [63:0] term;
		longint      acc;
		int          n;
		theta = (64'(k) * 64'(bup_pkg::HALF_PI_Q30)) >> (SINE_BITS - 2);
		sq = (theta * theta) >> 30;
		term = theta;
		acc = longint'(theta);
		for (n = 1; n <= bup_pkg::TAYLOR_TERMS; n++) begin
			term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		return 16'((acc + 32768) >>> 16);
	endfunction

	function automatic int sine_lookup(input int unsigned a);
		int unsigned quad;
		int unsigned k;
		int          v;
		quad = (a >> (SINE_BITS - 2)) & 3;
		k = a & (QUARTER - 1);
		if (quad & 1) begin
			k = (QUARTER - 1) - k;
		end
		v = int'(sine_tab[k]);
		return (quad & 2) ? -v : v;
	endfunction

	function automatic int unsigned phase_shift(input int unsigned base, input int p);
		longint s;
		s = longint'(p) * longint'(bup_pkg::INV_TWO_PI_Q32) * (longint'(1) << SINE_BITS);
		return (base + 32'(s >>> 46)) & ANG_MASK;
	endfunction

	function automatic int plot_pos(input int p, input int off, input int org);
		longint v;
		v = (longint'(p) * longint'(scale_q) + longint'(off) * 16384) * PLOT
			+ longint'(org) * (longint'(1) << 28);
		return (v >= 0) ? int'(v >>> 28) : -int'((-v) >>> 28);
	endfunction

	function automatic bup_pkg::rsp_t plot_next(input bup_pkg::req_t r);
		bup_pkg::rsp_t o;
		int unsigned clog;
		int unsigned ilog;
		int unsigned stp;
		int unsigned ccount;
		int unsigned icount;
		int unsigned red;
		int unsigned green;
		int unsigned blue;
		int unsigned inc1;
		logic [63:0] inc2;
		int unsigned a1;
		int unsigned a2;
		int          nx;
		int          ny;
		int          px;
		int          py;
		logic        on_scr;
		o = '0;
		clog = (curve_log2 < bup_pkg::LOG2_MIN) ? bup_pkg::LOG2_MIN :
			((curve_log2 > bup_pkg::CURVE_LOG2_MAX) ? bup_pkg::CURVE_LOG2_MAX : curve_log2);
		ilog = (iter_log2 < bup_pkg::LOG2_MIN) ? bup_pkg::LOG2_MIN :
			((iter_log2 > bup_pkg::ITER_LOG2_MAX) ? bup_pkg::ITER_LOG2_MAX : iter_log2);
		stp = (step_r == 0) ? 1 : step_r;
		ccount = 1 << clog;
		icount = 1 << ilog;
		if (r.command) begin
			frame_idle = 1'b0;
			curve_no = 0;
			iter_no = 0;
			x_pt = 0;
			y_pt = 0;
			angle1 = r.time_phase & ANG_MASK;
			angle2 = angle1;
		end
		if (!frame_idle && (curve_no >= ccount || iter_no >= icount)) begin
			frame_idle = 1'b1;
		end
		if (frame_idle) begin
			o.frame_done = 1'b1;
			return o;
		end
		a1 = phase_shift(angle1, x_pt);
		a2 = phase_shift(angle2, y_pt);
		nx = sine_lookup(a1) + sine_lookup(a2);
		ny = sine_lookup(a1 + QUARTER) + sine_lookup(a2 + QUARTER);
		px = plot_pos(nx, x_off, ORG_X);
		py = plot_pos(ny, y_off, ORG_Y);
		on_scr = px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H;
		red = (curve_no << 8) >> clog;
		green = (iter_no << 8) >> ilog;
		blue = 255 - (red + green) / 2;
		o.pixel_index = on_scr ? 14'(py * SCREEN_W + px) : '0;
		o.pixel_color = 16'(((red & 32'hF8) << 8) | ((green & 32'hFC) << 3) | (blue >> 3));
		o.pixel_valid = on_scr;
		if (iter_no + 1 >= icount) begin
			inc1 = ((stp << SINE_BITS) + bup_pkg::INC1_ROUND) / bup_pkg::INC1_DIV;
			inc2 = (((64'(stp) * 64'(bup_pkg::INV_TWO_PI_Q32)) << SINE_BITS)
				+ 64'h8000_0000) >> 32;
			o.curve_done = 1'b1;
			iter_no = 0;
			x_pt = 0;
			y_pt = 0;
			angle1 = (angle1 + inc1) & ANG_MASK;
			angle2 = (angle2 + 32'(inc2)) & ANG_MASK;
			if (curve_no + stp >= ccount) begin
				o.frame_done = 1'b1;
				frame_idle = 1'b1;
			end else begin
				curve_no = curve_no + stp;
			end
		end else begin
			iter_no = iter_no + 1;
			x_pt = nx;
			y_pt = ny;
		end
		return o;
	endfunction

	initial begin
		for (int k = 0; k < QUARTER; k++) begin
			sine_tab[k] = taylor_sine(k);
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		bup_pkg::rsp_t want;
		if (!arst_n) begin
			scale_q = bup_pkg::SIZE_SCALE_RST;
			x_off = int'(bup_pkg::X_OFFSET_RST);
			y_off = int'(bup_pkg::Y_OFFSET_RST);
			curve_log2 = bup_pkg::CURVE_LOG2_RST;
			iter_log2 = bup_pkg::ITER_LOG2_RST;
			step_r = bup_pkg::CURVE_STEP_RST;
			curve_no = 0;
			iter_no = 0;
			x_pt = 0;
			y_pt = 0;
			angle1 = 0;
			angle2 = 0;
			frame_idle = 1'b1;
			expected_points.delete();
			mism = 0;
			n_rsp = 0;
			n_pts = 0;
			n_on = 0;
			n_curves = 0;
			n_frames = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				n_rsp++;
				if (expected_points.size() == 0) begin
					mism++;
					if (mism <= 10) begin
						$display("%0t: response with no request outstanding: index %0d color %h",
							$realtime, rsp.pixel_index, rsp.pixel_color);
					end
				end else begin
					want = expected_points.pop_front();
					if (!want.frame_done || want.curve_done) begin
						n_pts++;
					end
					n_on += want.pixel_valid;
					n_curves += want.curve_done;
					n_frames += want.curve_done && want.frame_done;
					if (rsp.pixel_index !== want.pixel_index
						|| rsp.pixel_color !== want.pixel_color
						|| rsp.pixel_valid !== want.pixel_valid
						|| rsp.curve_done !== want.curve_done
						|| rsp.frame_done !== want.frame_done) begin
						mism++;
						if (mism <= 10) begin
							$display("%0t: mismatch, expected index %0d color %h valid %b %s %b %s %b",
								$realtime, want.pixel_index, want.pixel_color, want.pixel_valid,
								"curve_done", want.curve_done, "frame_done", want.frame_done);
							$display("%0t:           got      index %0d color %h valid %b %s %b %s %b",
								$realtime, rsp.pixel_index, rsp.pixel_color, rsp.pixel_valid,
								"curve_done", rsp.curve_done, "frame_done", rsp.frame_done);
						end
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					bup_pkg::REG_SIZE_SCALE: scale_q = cfg_data[14:0];
					bup_pkg::REG_X_OFFSET: x_off = int'($signed(cfg_data));
					bup_pkg::REG_Y_OFFSET: y_off = int'($signed(cfg_data));
					bup_pkg::REG_CURVE_LOG2: curve_log2 = cfg_data[3:0];
					bup_pkg::REG_ITERATION_LOG2: iter_log2 = cfg_data[3:0];
					bup_pkg::REG_CURVE_STEP: step_r = cfg_data[4:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				expected_points.push_back(plot_next(req));
			end
		end
		errors <= mism;
		pending <= expected_points.size();
		responses <= n_rsp;
		points <= n_pts;
		on_screen <= n_on;
		curves <= n_curves;
		frames <= n_frames;
	end

endmodule

>>> tb/tb_top.sv
// Testbench top of the bubble universe point plotter: clock, reset, stimulus and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SIB      = 16;
	localparam int SCREEN_W = 80;
	localparam int SCREEN_H = 160;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	bup_pkg::req_t                  req = '0;
	logic                           rsp_valid;
	logic                           rsp_stall = 1'b0;
	bup_pkg::rsp_t                  rsp;
	logic                           cfg_we = 1'b0;
	logic [bup_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bup_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int          errors;
	int          pending;
	int          responses;
	int          points;
	int          on_screen;
	int          curves;
	int          frames;
	int          items_sent = 0;
	int          settings_used = 0;
	stall_mode_t stall_mode;
	int          stall_left;
	int          stall_tick;

	bubble_universe_point_plotter #(
		.SINE_INDEX_BITS(SIB),
		.SCREEN_WIDTH(SCREEN_W),
		.SCREEN_HEIGHT(SCREEN_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bup_plot_checker #(
		.SINE_BITS(SIB),
		.SCREEN_W(SCREEN_W),
		.SCREEN_H(SCREEN_H)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.responses(responses),
		.points(points),
		.on_screen(on_screen),
		.curves(curves),
		.frames(frames)
	);

	always #10 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_left <= 0;
			stall_tick <= 0;
		end else begin
			stall_tick <= stall_tick + 1;
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(40, 400);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE: rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= stall_tick[1] ^ stall_tick[3];
			endcase
		end
	end

	task automatic send_req(input logic cmd, input logic [15:0] phase);
		req_valid <= 1'b1;
		req <= '{command: cmd, time_phase: phase};
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		items_sent++;
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bup_pkg::CFG_IDX_W-1:0] idx,
		input logic [bup_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [14:0] scale, input logic signed [16:0] xo,
		input logic signed [16:0] yo, input logic [3:0] clog, input logic [3:0] ilog,
		input logic [4:0] stp);
		settle();
		write_reg(bup_pkg::REG_SIZE_SCALE, 17'(scale));
		write_reg(bup_pkg::REG_X_OFFSET, xo);
		write_reg(bup_pkg::REG_Y_OFFSET, yo);
		write_reg(bup_pkg::REG_CURVE_LOG2, 17'(clog));
		write_reg(bup_pkg::REG_ITERATION_LOG2, 17'(ilog));
		write_reg(bup_pkg::REG_CURVE_STEP, 17'(stp));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	task automatic run_random(input int count, input int start_odds, input bit steady);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = steady ? left : $urandom_range(1, 12);
			if (burst > left) begin
				burst = left;
			end
			repeat (burst) send_req($urandom_range(0, start_odds - 1) == 0, 16'($urandom));
			left -= burst;
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin : stimulus
		logic [14:0]        scale;
		logic signed [16:0] xo;
		logic signed [16:0] yo;
		logic [3:0]         clog;
		logic [3:0]         ilog;
		logic [4:0]         stp;
		int                 odds;
		bit                 steady;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A request with no frame running, then the first points of two frames under the reset settings.
		send_req(1'b0, 16'hFFFF);
		send_req(1'b1, 16'h0000);
		repeat (3) send_req(1'b0, 16'($urandom));
		send_req(1'b1, 16'hFFFF);
		repeat (2) send_req(1'b0, 16'h0000);

		// Shrinking the point count below the current iteration ends the frame.
		apply_setting(bup_pkg::SIZE_SCALE_RST, bup_pkg::X_OFFSET_RST, bup_pkg::Y_OFFSET_RST,
			bup_pkg::CURVE_LOG2_RST, bup_pkg::LOG2_MIN, bup_pkg::CURVE_STEP_RST);
		repeat (2) send_req(1'b0, 16'($urandom));

		// Zero scale and step, log2 fields below range, offsets at both extremes.
		apply_setting(15'd0, -17'sd65536, 17'sd65535, 4'd0, 4'd0, 5'd0);
		send_req(1'b1, 16'h8000);
		repeat (5) send_req(1'b0, 16'($urandom));

		// Everything at its top value but the Y offset, which is at its bottom value.
		apply_setting(15'h7FFF, 17'sd65535, -17'sd65536, 4'hF, 4'hF, 5'h1F);
		send_req(1'b1, 16'h5555);
		repeat (3) send_req(1'b0, 16'hAAAA);

		// A step that covers the whole curve range in one move.
		apply_setting(15'd16383, 17'sd8192, 17'sd8192, 4'd4, 4'd1, 5'd16);
		send_req(1'b1, 16'h2AAA);
		repeat (3) send_req(1'b0, 16'($urandom));

		while (items_sent < 1700) begin
			scale = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(1024, 8192));
			xo = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(2048, 14336));
			yo = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(2048, 14336));
			clog = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
			ilog = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(1, 4));
			stp = ($urandom_range(0, 5) == 0) ? 5'($urandom) : 5'($urandom_range(1, 3));
			odds = ($urandom_range(0, 4) == 0) ? 2 : (1 << $urandom_range(3, 6));
			steady = ($urandom_range(0, 3) == 0);
			apply_setting(scale, xo, yo, clog, ilog, stp);
			run_random($urandom_range(20, 80), odds, steady);
		end

		settle();
		$display("Sent %0d requests under %0d register settings and checked %0d responses.",
			items_sent, settings_used, responses);
		$display("Plotted %0d points (%0d on screen), finished %0d curves and %0d frames.",
			points, on_screen, curves, frames);
		if (errors == 0) begin
			$display("** bubble_universe_point_plotter: PASSED **");
		end else begin
			$display("** bubble_universe_point_plotter: FAILED **");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Timed out with %0d responses still outstanding.", pending);
		$display("** bubble_universe_point_plotter: FAILED **");
		$finish;
	end

endmodule
